>>> hw/rtl/gpsm_pkg.sv
// Shared constants, types and helpers of the game-pad poll master.
package gpsm_pkg;

    localparam int MIN_FRAME       = 3;
    localparam int MAX_FRAME       = 21;
    localparam int FRAME_BYTES_DEF = 9;
    localparam int BYTE_IDX_W      = $clog2(MAX_FRAME + 1);
    // Only bytes 0..8 are ever read back (id, buttons, sticks).
    localparam int STORE_BYTES     = 9;
    localparam int STORE_IDX_W     = $clog2(STORE_BYTES);
    localparam int APB_ADDR_W      = 4;

    localparam logic [7:0]  CMD_POLL_START   = 8'h01;
    localparam logic [7:0]  CMD_POLL_READ    = 8'h42;
    localparam logic [7:0]  CMD_IDLE_BYTE    = 8'h00;
    localparam logic [7:0]  BYTE_RELEASED    = 8'hFF;
    localparam logic [7:0]  STICK_CENTER     = 8'h80;
    localparam logic [15:0] BUTTONS_RELEASED = 16'hFFFF;

    localparam logic [7:0] RST_SELECT_SETUP = 8'd10;
    localparam logic [7:0] RST_CLOCK_LOW    = 8'd50;
    localparam logic [7:0] RST_CLOCK_HIGH   = 8'd45;
    localparam logic [7:0] RST_BYTE_GAP     = 8'd10;

    typedef enum logic [1:0] {
        REG_SELECT_SETUP = 2'd0,
        REG_CLOCK_LOW    = 2'd1,
        REG_CLOCK_HIGH   = 2'd2,
        REG_BYTE_GAP     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] select_setup_ticks;
        logic [7:0] clock_low_ticks;
        logic [7:0] clock_high_ticks;
        logic [7:0] byte_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic        select_n;
        logic        clock_out;
        logic        command_out;
        logic        frame_done;
        logic [7:0]  device_id;
        logic [15:0] buttons;
        logic [15:0] buttons_changed;
        logic [4:0]  first_pressed;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
    } t_result;

    function automatic logic [7:0] cmd_byte(input logic [BYTE_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            BYTE_IDX_W'(0): b = CMD_POLL_START;
            BYTE_IDX_W'(1): b = CMD_POLL_READ;
            default:        b = CMD_IDLE_BYTE;
        endcase
        return b;
    endfunction

    function automatic int clamp_frame(input int n);
        if (n < MIN_FRAME) return MIN_FRAME;
        if (n > MAX_FRAME) return MAX_FRAME;
        return n;
    endfunction

endpackage

>>> hw/rtl/gpsm_chan_if.sv
// Valid/ready channel interfaces for poll ticks and poll results.
interface gpsm_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic dat_in;

    modport source (output valid, output start_req, output dat_in, input ready);
    modport sink   (input valid, input start_req, input dat_in, output ready);
endinterface

interface gpsm_out_if;
    logic        valid;
    logic        ready;
    logic        select_n;
    logic        clock_out;
    logic        command_out;
    logic        frame_done;
    logic [7:0]  device_id;
    logic [15:0] buttons;
    logic [15:0] buttons_changed;
    logic [4:0]  first_pressed;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;

    modport source (
        output valid, input ready,
        output select_n, output clock_out, output command_out, output frame_done,
        output device_id, output buttons, output buttons_changed, output first_pressed,
        output right_x, output right_y, output left_x, output left_y
    );
    modport sink (
        input valid, output ready,
        input select_n, input clock_out, input command_out, input frame_done,
        input device_id, input buttons, input buttons_changed, input first_pressed,
        input right_x, input right_y, input left_x, input left_y
    );
endinterface

>>> hw/rtl/gpsm_apb_regs.sv
// APB timing registers of the poll master.
module gpsm_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gpsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output gpsm_pkg::t_cfg                    o_cfg
);
    import gpsm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic [7:0] w_rd;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.select_setup_ticks <= RST_SELECT_SETUP;
            r_cfg.clock_low_ticks    <= RST_CLOCK_LOW;
            r_cfg.clock_high_ticks   <= RST_CLOCK_HIGH;
            r_cfg.byte_gap_ticks     <= RST_BYTE_GAP;
        end else if (w_wr) begin
            case (w_idx)
                REG_SELECT_SETUP: r_cfg.select_setup_ticks <= pwdata[7:0];
                REG_CLOCK_LOW:    r_cfg.clock_low_ticks    <= pwdata[7:0];
                REG_CLOCK_HIGH:   r_cfg.clock_high_ticks   <= pwdata[7:0];
                REG_BYTE_GAP:     r_cfg.byte_gap_ticks     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SELECT_SETUP: w_rd = r_cfg.select_setup_ticks;
            REG_CLOCK_LOW:    w_rd = r_cfg.clock_low_ticks;
            REG_CLOCK_HIGH:   w_rd = r_cfg.clock_high_ticks;
            REG_BYTE_GAP:     w_rd = r_cfg.byte_gap_ticks;
            default:          w_rd = 8'd0;
        endcase
    end

    assign prdata = {24'd0, w_rd};

endmodule

>>> hw/rtl/gpsm_core.sv
// Pin sequencer of the poll master: one tick of state per accepted transfer.
module gpsm_core #(
    parameter int FRAME_BYTES = gpsm_pkg::FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_start_req,
    input  logic              i_dat_in,
    input  gpsm_pkg::t_cfg    i_cfg,
    output gpsm_pkg::t_result o_result
);
    import gpsm_pkg::*;

    localparam int FB_EFF = clamp_frame(FRAME_BYTES);
    localparam logic [BYTE_IDX_W-1:0] LAST_COUNT = BYTE_IDX_W'(FB_EFF);
    localparam logic [BYTE_IDX_W-1:0] STORE_LIM  = BYTE_IDX_W'(STORE_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_LOW   = 3'd2,
        PH_HIGH  = 3'd3,
        PH_GAP   = 3'd4
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [7:0]            r_tick, n_tick;
    logic [2:0]            r_bit, n_bit;
    logic [BYTE_IDX_W-1:0] r_byte, n_byte;
    logic [7:0]            r_rx, n_rx;
    logic [7:0]            r_fb [STORE_BYTES];
    logic [7:0]            n_fb [STORE_BYTES];
    logic [15:0]           r_now, n_now;
    logic [15:0]           r_prev, n_prev;
    logic                  w_done;
    logic [7:0]            w_tick_inc;
    logic [15:0]           w_inv;
    logic [4:0]            w_first;
    logic [7:0]            w_cmd;

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    assign w_tick_inc = r_tick + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_rx    = r_rx;
        n_fb    = r_fb;
        n_now   = r_now;
        n_prev  = r_prev;
        w_done  = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_bit   = 3'd0;
                    n_byte  = '0;
                    n_rx    = 8'd0;
                    n_tick  = 8'd0;
                    n_phase = (i_cfg.select_setup_ticks == 8'd0) ? PH_LOW : PH_SETUP;
                end
            end
            PH_SETUP: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= i_cfg.select_setup_ticks) begin
                    n_phase = PH_LOW;
                    n_tick  = 8'd0;
                end
            end
            PH_LOW: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= at_least_one(i_cfg.clock_low_ticks)) begin
                    // rising edge: sample data, store byte on its last bit
                    n_rx = r_rx | (8'(i_dat_in) << r_bit);
                    if (r_bit == 3'd7 && r_byte < STORE_LIM) begin
                        n_fb[r_byte[STORE_IDX_W-1:0]] = n_rx;
                    end
                    n_phase = PH_HIGH;
                    n_tick  = 8'd0;
                end
            end
            PH_HIGH: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= at_least_one(i_cfg.clock_high_ticks)) begin
                    n_tick = 8'd0;
                    if (r_bit == 3'd7) begin
                        n_bit  = 3'd0;
                        n_rx   = 8'd0;
                        n_byte = r_byte + BYTE_IDX_W'(1);
                        if (n_byte >= LAST_COUNT) begin
                            n_prev     = r_now;
                            n_now[7:0] = (FB_EFF > 3) ? r_fb[3] : BYTE_RELEASED;
                            n_now[15:8] = (FB_EFF > 4) ? r_fb[4] : BYTE_RELEASED;
                            n_phase    = PH_IDLE;
                            n_byte     = '0;
                            w_done     = 1'b1;
                        end else begin
                            n_phase = (i_cfg.byte_gap_ticks == 8'd0) ? PH_LOW : PH_GAP;
                        end
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_LOW;
                    end
                end
            end
            PH_GAP: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= i_cfg.byte_gap_ticks) begin
                    n_phase = PH_LOW;
                    n_tick  = 8'd0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 8'd0;
            r_bit   <= 3'd0;
            r_byte  <= '0;
            r_rx    <= 8'd0;
            for (int i = 0; i < STORE_BYTES; i++) begin
                r_fb[i] <= 8'd0;
            end
            r_now   <= BUTTONS_RELEASED;
            r_prev  <= BUTTONS_RELEASED;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_rx    <= n_rx;
            r_fb    <= n_fb;
            r_now   <= n_now;
            r_prev  <= n_prev;
        end
    end

    // Result reflects the pins after this tick's update.
    assign w_inv = ~n_now;
    assign w_cmd = cmd_byte(n_byte);

    always_comb begin
        w_first = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (w_inv[i]) begin
                w_first = 5'(i + 1);
            end
        end
    end

    always_comb begin
        o_result.select_n        = (n_phase == PH_IDLE);
        o_result.clock_out       = (n_phase != PH_LOW);
        o_result.command_out     = (n_phase != PH_IDLE) & w_cmd[n_bit];
        o_result.frame_done      = w_done;
        o_result.device_id       = n_fb[1];
        o_result.buttons         = w_inv;
        o_result.buttons_changed = n_now ^ n_prev;
        o_result.first_pressed   = w_first;
        o_result.right_x         = (FB_EFF > 5) ? n_fb[5] : STICK_CENTER;
        o_result.right_y         = (FB_EFF > 6) ? n_fb[6] : STICK_CENTER;
        o_result.left_x          = (FB_EFF > 7) ? n_fb[7] : STICK_CENTER;
        o_result.left_y          = (FB_EFF > 8) ? n_fb[8] : STICK_CENTER;
    end

    a_idle_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bit == 3'd0 && r_byte == '0))
        else $error("bit/byte position not cleared while idle");

    a_byte_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte < LAST_COUNT)
        else $error("byte position ran past frame length");

    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_tick) && $stable(r_now)))
        else $error("sequencer moved without a tick");

    a_buttons_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !w_done) |=> $stable(r_now))
        else $error("button word changed outside frame end");

endmodule

>>> hw/rtl/gpsm_skid.sv
// Output register with skid stage for the poll results.
module gpsm_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gpsm_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output gpsm_pkg::t_result o_data
);
    import gpsm_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_push;
    logic    w_pop;

    assign o_ready = ~r_skid_valid;
    assign w_push  = i_valid & ~r_skid_valid;
    assign w_pop   = r_out_valid & i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_push;
                end
            end else if (w_push) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (w_push && (w_pop || !r_out_valid)) begin
            r_out <= i_data;
        end
        if (w_push && r_out_valid && !w_pop) begin
            r_skid <= i_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

endmodule

>>> hw/rtl/gamepad_poll_serial_master_unit.sv
// Top level of the game-pad poll master: APB timing registers, sequencer, result buffer.
// Each transfer on i_in is one timing tick of the pad's pin sequencer and yields exactly
// one result transfer on o_out holding the pin levels after that tick (select_n,
// clock_out, command_out), a one-tick frame_done pulse and the decoded pad data. A frame
// starts on start_req while idle: select drops, the block waits select_setup_ticks, then
// shifts FRAME_BYTES command bytes LSB first (0x01, 0x42, then zeros). Each bit spends
// clock_low_ticks with clock low, samples dat_in on the rising tick, and holds clock high
// for clock_high_ticks; byte_gap_ticks of idle clock-high separate bytes. Zero low/high
// times act as one tick; zero setup or gap skips that phase. Buttons (active high), the
// changed mask and first_pressed update only at frame end; device_id and the sticks track
// the receive buffer byte by byte. Rate: one tick per clock cycle while i_in.ready is high;
// next-state logic is combinational and each result is registered in the output register
// or, while that holds a result, in the skid entry. A two-entry output buffer (output
// register plus skid) lets ticks flow while a result waits; i_in.ready drops only when both
// entries are full. Timing registers are at byte addresses 0, 4, 8, 12 and should only be
// written while no ticks are in flight.
module gamepad_poll_serial_master_unit #(
    parameter int FRAME_BYTES = gpsm_pkg::FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gpsm_in_if.sink                         i_in,
    gpsm_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gpsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import gpsm_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result w_out_data;
    logic    w_in_ready;
    logic    w_step;

    gpsm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // a tick advances the sequencer only when its result has a slot
    assign i_in.ready = w_in_ready;
    assign w_step     = i_in.valid & w_in_ready;

    gpsm_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_start_req (i_in.start_req),
        .i_dat_in    (i_in.dat_in),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    gpsm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_in_ready),
        .i_data  (w_result),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_out_data)
    );

    assign o_out.select_n        = w_out_data.select_n;
    assign o_out.clock_out       = w_out_data.clock_out;
    assign o_out.command_out     = w_out_data.command_out;
    assign o_out.frame_done      = w_out_data.frame_done;
    assign o_out.device_id       = w_out_data.device_id;
    assign o_out.buttons         = w_out_data.buttons;
    assign o_out.buttons_changed = w_out_data.buttons_changed;
    assign o_out.first_pressed   = w_out_data.first_pressed;
    assign o_out.right_x         = w_out_data.right_x;
    assign o_out.right_y         = w_out_data.right_y;
    assign o_out.left_x          = w_out_data.left_x;
    assign o_out.left_y          = w_out_data.left_y;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the game-pad poll master: tick stream in, pin and pad reports out.
module tb;
    import gpsm_pkg::*;

    // Frame length as the block sees it (default parameter, held to the legal range).
    localparam int FRAME_LEN = (FRAME_BYTES_DEF < MIN_FRAME) ? MIN_FRAME :
                               (FRAME_BYTES_DEF > MAX_FRAME) ? MAX_FRAME : FRAME_BYTES_DEF;

    // Sequencer phases of the pin engine.
    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'd0,
        SEQ_SETUP = 3'd1,
        SEQ_LOW   = 3'd2,
        SEQ_HIGH  = 3'd3,
        SEQ_GAP   = 3'd4
    } t_seq_phase;

    // Full state of one poll engine: timing position plus received data.
    typedef struct packed {
        t_seq_phase                  phase;
        logic [7:0]                  ticks;
        logic [2:0]                  bit_idx;
        logic [BYTE_IDX_W-1:0]       byte_idx;
        logic [7:0]                  shift_in;
        logic [MAX_FRAME-1:0][7:0]   rx_bytes;
        logic [15:0]                 raw_now;
        logic [15:0]                 raw_prev;
    } t_pad_seq;

    typedef struct packed {
        logic start_req;
        logic dat_in;
    } t_tick;

    // Bytes the pad sends back during one frame.
    typedef logic [MAX_FRAME-1:0][7:0] t_reply;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  tx_valid = 1'b0;
    logic                  tx_start = 1'b0;
    logic                  tx_dat   = 1'b0;
    logic                  rx_ready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    gpsm_in_if  in_ch();
    gpsm_out_if out_ch();

    assign in_ch.valid     = tx_valid;
    assign in_ch.start_req = tx_start;
    assign in_ch.dat_in    = tx_dat;
    assign out_ch.ready    = rx_ready;

    gamepad_poll_serial_master_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Timing registers as last written; only changed while nothing is in flight.
    t_cfg     timing = '{RST_SELECT_SETUP, RST_CLOCK_LOW, RST_CLOCK_HIGH, RST_BYTE_GAP};
    // pad_model tracks accepted ticks; pad_plan runs ahead while stimulus is built,
    // so the generator knows which tick samples dat_in.
    t_pad_seq pad_model;
    t_pad_seq pad_plan;

    t_tick    pending_ticks[$];
    t_result  predicted_pins[$];

    int       sent_count     = 0;
    int       planned_count  = 0;
    int       mismatch_count = 0;
    int       pressure_at    = 32'h7fff_ffff;
    int       send_gap       = 0;
    int       recv_gap       = 0;
    logic     calm           = 1'b0;
    logic     hold_rx        = 1'b0;
    t_result  pins;
    t_tick    head_tick;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // Poll engine predictor
    // ---------------------------------------------------------------------------------

    function automatic t_pad_seq idle_pad();
        t_pad_seq s;
        s          = '0;
        s.phase    = SEQ_IDLE;
        s.raw_now  = BUTTONS_RELEASED;
        s.raw_prev = BUTTONS_RELEASED;
        return s;
    endfunction

    // Zero low/high time behaves as a single tick.
    function automatic logic [7:0] min_one_tick(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [7:0] command_byte(input logic [BYTE_IDX_W-1:0] idx);
        if (idx == BYTE_IDX_W'(0)) return CMD_POLL_START;
        if (idx == BYTE_IDX_W'(1)) return CMD_POLL_READ;
        return CMD_IDLE_BYTE;
    endfunction

    // Received byte, or a filler when the frame is too short to carry it.
    function automatic logic [7:0] rx_or(input t_pad_seq s, input int idx,
                                         input logic [7:0] dflt);
        return (idx < FRAME_LEN) ? s.rx_bytes[idx] : dflt;
    endfunction

    // One tick of the pin engine; r gets the pin levels and decoded pad data after it.
    function automatic void advance_pad_tick(inout t_pad_seq s, input t_cfg c,
                                             input logic start, input logic dat,
                                             output t_result r);
        logic        done;
        logic [7:0]  cmd;
        logic [15:0] inv;
        int          i;
        done = 1'b0;
        case (s.phase)
            SEQ_IDLE: begin
                // start_req is only looked at here; while busy it is dropped
                if (start) begin
                    s.bit_idx  = '0;
                    s.byte_idx = '0;
                    s.shift_in = '0;
                    s.ticks    = '0;
                    s.phase    = (c.select_setup_ticks == 8'd0) ? SEQ_LOW : SEQ_SETUP;
                end
            end
            SEQ_SETUP: begin
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= c.select_setup_ticks) begin
                    s.phase = SEQ_LOW;
                    s.ticks = '0;
                end
            end
            SEQ_LOW: begin
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= min_one_tick(c.clock_low_ticks)) begin
                    // rising clock: sample data, LSB first
                    if (dat) s.shift_in[s.bit_idx] = 1'b1;
                    if (s.bit_idx == 3'd7 && s.byte_idx < BYTE_IDX_W'(MAX_FRAME))
                        s.rx_bytes[s.byte_idx] = s.shift_in;
                    s.phase = SEQ_HIGH;
                    s.ticks = '0;
                end
            end
            SEQ_HIGH: begin
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= min_one_tick(c.clock_high_ticks)) begin
                    if (s.bit_idx == 3'd7) begin
                        s.bit_idx  = '0;
                        s.shift_in = '0;
                        s.byte_idx = s.byte_idx + BYTE_IDX_W'(1);
                        if (s.byte_idx >= BYTE_IDX_W'(FRAME_LEN)) begin
                            // end of frame: latch buttons, release select
                            s.raw_prev = s.raw_now;
                            s.raw_now  = {rx_or(s, 4, BYTE_RELEASED),
                                          rx_or(s, 3, BYTE_RELEASED)};
                            s.phase    = SEQ_IDLE;
                            s.ticks    = '0;
                            s.byte_idx = '0;
                            done       = 1'b1;
                        end else begin
                            s.phase = (c.byte_gap_ticks == 8'd0) ? SEQ_LOW : SEQ_GAP;
                            s.ticks = '0;
                        end
                    end else begin
                        s.bit_idx = s.bit_idx + 3'd1;
                        s.phase   = SEQ_LOW;
                        s.ticks   = '0;
                    end
                end
            end
            SEQ_GAP: begin
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= c.byte_gap_ticks) begin
                    s.phase = SEQ_LOW;
                    s.ticks = '0;
                end
            end
            default: begin
                s.phase = SEQ_IDLE;
                s.ticks = '0;
            end
        endcase

        cmd               = command_byte(s.byte_idx);
        inv               = ~s.raw_now;
        r.select_n        = (s.phase == SEQ_IDLE);
        r.clock_out       = (s.phase != SEQ_LOW);
        r.command_out     = r.select_n ? 1'b0 : cmd[s.bit_idx];
        r.frame_done      = done;
        r.device_id       = s.rx_bytes[1];
        r.buttons         = inv;
        r.buttons_changed = s.raw_now ^ s.raw_prev;
        r.first_pressed   = '0;
        for (i = 15; i >= 0; i--) begin
            if (inv[i]) r.first_pressed = 5'(i + 1);
        end
        r.right_x         = rx_or(s, 5, STICK_CENTER);
        r.right_y         = rx_or(s, 6, STICK_CENTER);
        r.left_x          = rx_or(s, 7, STICK_CENTER);
        r.left_y          = rx_or(s, 8, STICK_CENTER);
    endfunction

    // ---------------------------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------------------------

    task automatic push_tick(input logic start, input logic dat);
        t_result scratch;
        t_tick   item;
        advance_pad_tick(pad_plan, timing, start, dat, scratch);
        item.start_req = start;
        item.dat_in    = dat;
        pending_ticks.push_back(item);
        planned_count++;
    endtask

    // Pad reply: 0xFF, id, 0x5A, two button bytes (active low), four stick bytes.
    function automatic t_reply make_reply(input logic [7:0] id, input logic [15:0] pressed,
                                          input logic [7:0] rx, input logic [7:0] ry,
                                          input logic [7:0] lx, input logic [7:0] ly);
        t_reply rep;
        rep    = '0;
        rep[0] = 8'hFF;
        rep[1] = id;
        rep[2] = 8'h5A;
        rep[3] = ~pressed[7:0];
        rep[4] = ~pressed[15:8];
        rep[5] = rx;
        rep[6] = ry;
        rep[7] = lx;
        rep[8] = ly;
        return rep;
    endfunction

    function automatic logic [7:0] stick_pick();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return STICK_CENTER;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_reply random_reply();
        logic [15:0] pressed;
        t_reply      rep;
        case ($urandom_range(0, 3))
            0:       pressed = '0;
            1:       pressed = 16'd1 << $urandom_range(0, 15);
            2:       pressed = 16'($urandom);
            default: pressed = ~(16'd1 << $urandom_range(0, 15));
        endcase
        rep    = make_reply(8'($urandom), pressed, stick_pick(), stick_pick(),
                            stick_pick(), stick_pick());
        rep[0] = 8'($urandom);
        rep[2] = 8'($urandom);
        return rep;
    endfunction

    // One full poll: some idle ticks, the start tick, then ticks until the frame ends.
    // Only the sampling tick carries the reply bit; all others get random data.
    // garble scrambles the sampled bits, hold_start keeps start_req high while busy.
    task automatic send_frame(input t_reply rep, input int lead, input bit garble,
                              input bit hold_start);
        int   k;
        logic sample;
        logic dat;
        for (k = 0; k < lead; k++) push_tick(1'b0, 1'($urandom_range(0, 1)));
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        while (pad_plan.phase != SEQ_IDLE) begin
            sample = (pad_plan.phase == SEQ_LOW) &&
                     (int'(pad_plan.ticks) + 1 >= int'(min_one_tick(timing.clock_low_ticks)));
            dat    = (sample && !garble) ? rep[pad_plan.byte_idx][pad_plan.bit_idx]
                                         : 1'($urandom_range(0, 1));
            push_tick(hold_start ? 1'b1 : 1'($urandom_range(0, 1)), dat);
        end
    endtask

    task automatic random_phase(input int budget);
        int stop_at;
        stop_at = planned_count + budget;
        while (planned_count < stop_at) begin
            send_frame(random_reply(), $urandom_range(0, 4), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 15) == 0);
            repeat ($urandom_range(0, 3)) push_tick(1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until every tick is sent and every report checked, plus the output latency.
    task automatic settle();
        while (pending_ticks.size() != 0 || tx_valid || predicted_pins.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SELECT_SETUP: timing.select_setup_ticks = value;
            REG_CLOCK_LOW:    timing.clock_low_ticks    = value;
            REG_CLOCK_HIGH:   timing.clock_high_ticks   = value;
            default:          timing.byte_gap_ticks     = value;
        endcase
    endtask

    // APB read: setup cycle, access cycle, data checked when pready is high.
    task automatic check_reg(input t_reg_idx idx, input logic [7:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {24'd0, want}) begin
            $display("%0t ns: register %0d expected %h got %h", $time, int'(idx),
                     {24'd0, want}, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_timing(input logic [7:0] setup, input logic [7:0] low,
                                  input logic [7:0] high, input logic [7:0] gap);
        write_reg(REG_SELECT_SETUP, setup);
        write_reg(REG_CLOCK_LOW, low);
        write_reg(REG_CLOCK_HIGH, high);
        write_reg(REG_BYTE_GAP, gap);
    endtask

    // ---------------------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_report();
        t_result want;
        if (predicted_pins.size() == 0) begin
            $display("%0t ns: report with none pending, expected nothing got select_n=%b",
                     $time, out_ch.select_n);
            mismatch_count++;
        end else begin
            want = predicted_pins.pop_front();
            compare_field("select_n", 16'(want.select_n), 16'(out_ch.select_n));
            compare_field("clock_out", 16'(want.clock_out), 16'(out_ch.clock_out));
            compare_field("command_out", 16'(want.command_out), 16'(out_ch.command_out));
            compare_field("frame_done", 16'(want.frame_done), 16'(out_ch.frame_done));
            compare_field("device_id", 16'(want.device_id), 16'(out_ch.device_id));
            compare_field("buttons", want.buttons, out_ch.buttons);
            compare_field("buttons_changed", want.buttons_changed, out_ch.buttons_changed);
            compare_field("first_pressed", 16'(want.first_pressed),
                          16'(out_ch.first_pressed));
            compare_field("right_x", 16'(want.right_x), 16'(out_ch.right_x));
            compare_field("right_y", 16'(want.right_y), 16'(out_ch.right_y));
            compare_field("left_x", 16'(want.left_x), 16'(out_ch.left_x));
            compare_field("left_y", 16'(want.left_y), 16'(out_ch.left_y));
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Tick driver: one pending tick per transfer, random idle bursts between them.
    // The predictor steps on every accepted transfer, so predictions follow the
    // order the block actually sees.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
            send_gap  = 0;
        end else begin
            if (tx_valid && in_ch.ready) begin
                advance_pad_tick(pad_model, timing, tx_start, tx_dat, pins);
                predicted_pins.push_back(pins);
                sent_count++;
            end
            if (!tx_valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    tx_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    head_tick = pending_ticks.pop_front();
                    tx_valid <= 1'b1;
                    tx_start <= head_tick.start_req;
                    tx_dat   <= head_tick.dat_in;
                    if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 9);
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Report monitor: checks every transfer on the output; ready stalls in bursts and
    // drops for the long hold-off below.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            recv_gap  = 0;
        end else begin
            if (out_ch.valid && rx_ready) check_report();
            if (hold_rx) begin
                rx_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
                if (!calm && $urandom_range(0, 11) == 0) recv_gap = $urandom_range(1, 9);
            end
        end
    end

    // Long receiver hold-off during the first frame: the two-entry output buffer
    // fills and the block has to push back on the tick channel.
    initial begin
        while (sent_count < pressure_at) @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (48) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #80_000_000;
        $display("gamepad_poll_serial_master_unit regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    initial begin
        pad_model = idle_pad();
        pad_plan  = idle_pad();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Timing registers read back their reset values.
        check_reg(REG_SELECT_SETUP, RST_SELECT_SETUP);
        check_reg(REG_CLOCK_LOW, RST_CLOCK_LOW);
        check_reg(REG_CLOCK_HIGH, RST_CLOCK_HIGH);
        check_reg(REG_BYTE_GAP, RST_BYTE_GAP);

        // Idle ticks show the reset pin levels and released buttons.
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        settle();

        // Reset setup and gap times; zero clock times act as one tick.
        // All buttons pressed, sticks at the low end; the receiver stalls mid-frame.
        write_reg(REG_CLOCK_LOW, 8'd0);
        write_reg(REG_CLOCK_HIGH, 8'd0);
        pressure_at = sent_count + 80;
        send_frame(make_reply(8'h73, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00), 1, 1'b0, 1'b0);
        settle();

        // Zero setup and gap skip those phases; only the top button, start held high
        // through the frame.
        program_timing(8'd0, 8'd0, 8'd0, 8'd0);
        send_frame(make_reply(8'h41, 16'h8000, 8'hFF, STICK_CENTER, 8'h00, 8'h7F),
                   0, 1'b0, 1'b1);
        settle();

        // closing stretch at full rate on both sides
        calm <= 1'b1;
        program_timing(8'd1, 8'd2, 8'd1, 8'd1);
        random_phase(100);
        settle();

        if (mismatch_count == 0) begin
            $display("gamepad_poll_serial_master_unit regression: pass");
        end else begin
            $display("gamepad_poll_serial_master_unit regression: fail");
        end
        $finish;
    end

endmodule
